[rtl/pti_pkg.sv]
package pti_pkg;

    localparam int CODE_W   = 32;
    localparam int NODE_W   = 13;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOLLOW     = 3'd0,
        ST_ADDED      = 3'd1,
        ST_ROOT       = 3'd2,
        ST_NODE_FULL  = 3'd3,
        ST_TABLE_FULL = 3'd4
    } status_t;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_SEP  = 1'b1;

endpackage

[rtl/pti_ram.sv]
module pti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/prefix_tree_token_insert.sv]
// channel | ports                                        | dir
// s_      | s_valid s_ready s_kind s_move_code           | in
// m_      | m_valid m_ready m_cursor_node m_status       | out
//         | m_node_count                                 |
//
// each beat is a read step (node row and child count from memory), then a
// compare step (all children in parallel, row written back on an add).
// a newly allocated node has its child count cleared in the following cycle.
// reset clears the cursor, the node count, the pending child-count clear and the handshake state only.
// a stalled result holds the block in the compare step until it is taken.
module prefix_tree_token_insert #(
    parameter int NODES    = 4096,
    parameter int CHILDREN = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [pti_pkg::CODE_W-1:0]   s_move_code,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pti_pkg::NODE_W-1:0]   m_cursor_node,
    output logic [pti_pkg::STATUS_W-1:0] m_status,
    output logic [pti_pkg::NODE_W-1:0]   m_node_count
);

    import pti_pkg::*;

    localparam int AW    = $clog2(NODES);
    localparam int NW    = $clog2(NODES + 1);
    localparam int CW    = $clog2(CHILDREN + 1);
    localparam int SW    = CODE_W + NW;
    localparam int ROW_W = CHILDREN * SW;

    typedef enum logic {
        IDLE,
        EVAL
    } state_t;

    state_t              state_reg, state_next;
    logic [NW-1:0]       cursor_reg, cursor_next;
    logic [NW-1:0]       alloc_reg, alloc_next;
    logic                kind_reg;
    logic [CODE_W-1:0]   code_reg;
    logic                m_valid_reg, m_valid_next;
    logic [NODE_W-1:0]   m_cursor_reg, m_cursor_next;
    status_t             m_status_reg, m_status_next;
    logic [NODE_W-1:0]   m_count_reg, m_count_next;
    logic                clr_reg, clr_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;

    logic                accept;
    logic                eval_fire;
    logic [ROW_W-1:0]    row_rd, row_wr;
    logic [CW-1:0]       cnt_rd, cnt_wr;
    logic                row_we, cnt_we;
    logic [AW-1:0]       cnt_waddr;

    logic [CW-1:0]       n_clamp;
    logic [CHILDREN-1:0] hit;
    logic                hit_any;
    logic [CW-1:0]       slot;
    logic                do_add;
    logic [NW-1:0]       new_node;
    logic [NW-1:0]       hit_target;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == IDLE);
    assign eval_fire = (state_reg == EVAL) && (!m_valid_reg || m_ready);

    pti_ram #(.WIDTH(ROW_W), .DEPTH(NODES)) u_row_ram (
        .clk     (aclk),
        .wr_en   (row_we),
        .wr_addr (cursor_reg[AW-1:0]),
        .wr_data (row_wr),
        .rd_en   (accept),
        .rd_addr (cursor_reg[AW-1:0]),
        .rd_data (row_rd)
    );

    pti_ram #(.WIDTH(CW), .DEPTH(NODES)) u_cnt_ram (
        .clk     (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wr),
        .rd_en   (accept),
        .rd_addr (cursor_reg[AW-1:0]),
        .rd_data (cnt_rd)
    );

    // parallel child compare, lowest matching slot wins
    always_comb begin
        n_clamp = (cnt_rd > CW'(CHILDREN)) ? CW'(CHILDREN) : cnt_rd;
        for (int i = 0; i < CHILDREN; i++) begin
            hit[i] = (CW'(i) < n_clamp) && (row_rd[i*SW +: CODE_W] == code_reg);
        end
        hit_any    = |hit;
        hit_target = '0;
        for (int i = CHILDREN - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_target = row_rd[i*SW + CODE_W +: NW];
            end
        end
    end

    always_comb begin
        status_t st;
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        alloc_next    = alloc_reg;
        m_valid_next  = m_valid_reg;
        m_cursor_next = m_cursor_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        clr_next      = 1'b0;
        clr_addr_next = clr_addr_reg;
        do_add        = 1'b0;
        slot          = '0;
        new_node      = alloc_reg + NW'(1);
        st            = ST_FOLLOW;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE: begin
                if (accept) begin
                    state_next = EVAL;
                end
            end
            EVAL: begin
                if (eval_fire) begin
                    state_next = IDLE;
                    if (kind_reg == KIND_SEP) begin
                        cursor_next = '0;
                        st          = ST_ROOT;
                    end else if (alloc_reg >= NW'(NODES) || cursor_reg >= NW'(NODES)) begin
                        st = ST_TABLE_FULL;
                    end else if (cursor_reg == alloc_reg) begin
                        do_add = 1'b1;
                        slot   = '0;
                    end else if (hit_any) begin
                        cursor_next = hit_target;
                        st          = ST_FOLLOW;
                    end else if (n_clamp < CW'(CHILDREN)) begin
                        do_add = 1'b1;
                        slot   = n_clamp;
                    end else begin
                        st = ST_NODE_FULL;
                    end
                    if (do_add) begin
                        st          = ST_ADDED;
                        alloc_next  = new_node;
                        cursor_next = new_node;
                        // fresh node starts with no children
                        clr_next      = (new_node < NW'(NODES));
                        clr_addr_next = new_node[AW-1:0];
                    end
                    m_valid_next  = 1'b1;
                    m_cursor_next = NODE_W'(cursor_next);
                    m_status_next = st;
                    m_count_next  = NODE_W'(alloc_next);
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    // row write-back with the new child spliced in
    always_comb begin
        row_wr = row_rd;
        for (int i = 0; i < CHILDREN; i++) begin
            if (CW'(i) == slot) begin
                row_wr[i*SW +: CODE_W]      = code_reg;
                row_wr[i*SW + CODE_W +: NW] = new_node;
            end
        end
    end

    assign row_we    = eval_fire && do_add;
    assign cnt_we    = row_we || clr_reg;
    assign cnt_waddr = clr_reg ? clr_addr_reg : cursor_reg[AW-1:0];
    assign cnt_wr    = clr_reg ? '0 : slot + CW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cursor_reg  <= '0;
            alloc_reg   <= '0;
            m_valid_reg <= 1'b0;
            clr_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            alloc_reg   <= alloc_next;
            m_valid_reg <= m_valid_next;
            clr_reg     <= clr_next;
        end
        if (accept) begin
            kind_reg <= s_kind;
            code_reg <= s_move_code;
        end
        clr_addr_reg <= clr_addr_next;
        m_cursor_reg <= m_cursor_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_cursor_node = m_cursor_reg;
    assign m_status      = m_status_reg;
    assign m_node_count  = m_count_reg;

endmodule

[rtl/pti_checker.sv]
module pti_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [pti_pkg::NODE_W-1:0]   m_cursor_node,
    input logic [pti_pkg::STATUS_W-1:0] m_status,
    input logic [pti_pkg::NODE_W-1:0]   m_node_count
);

    import pti_pkg::*;

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_cursor_node)
            && $stable(m_node_count))
        else $error("stalled result beat changed");

    // one beat in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous beat still in work");

    a_root: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ROOT |-> m_cursor_node == '0)
        else $error("separator did not return cursor to root");

    a_added: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ADDED |-> m_cursor_node == m_node_count)
        else $error("added child is not the newest node");

endmodule

bind prefix_tree_token_insert pti_checker u_pti_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_cursor_node (m_cursor_node),
    .m_status      (m_status),
    .m_node_count  (m_node_count)
);
